@@ hdl/spq_pkg.sv @@
// Shared sizes, codes and control types for the sorted insert priority queue.
`default_nettype none

package spq_pkg;

   // Queue geometry and field widths.
   localparam int QUEUE_DEPTH  = 256;
   localparam int KEY_BITS     = 24;
   localparam int PAYLOAD_BITS = 9;
   localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int STATUS_BITS  = 2;

   // Request kinds.
   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   // Response status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Operation broadcast from the control logic to every cell.
   typedef struct packed {
      logic                    ins;
      logic                    rem;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ hdl/spq_cell.sv @@
// One storage cell of the queue: holds one entry and trades it with its neighbors.
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic                    clock,
   input  wire cell_ctrl_type           ctrl,
   input  wire logic                    occupied,
   input  wire logic                    left_gt,
   input  wire logic [KEY_BITS-1:0]     left_key,
   input  wire logic [PAYLOAD_BITS-1:0] left_payload,
   input  wire logic [KEY_BITS-1:0]     right_key,
   input  wire logic [PAYLOAD_BITS-1:0] right_payload,
   output logic                         gt,
   output logic [KEY_BITS-1:0]          key,
   output logic [PAYLOAD_BITS-1:0]      payload
);

   logic [KEY_BITS-1:0]     key_ff;
   logic [KEY_BITS-1:0]     key_in;
   logic [PAYLOAD_BITS-1:0] payload_ff;
   logic [PAYLOAD_BITS-1:0] payload_in;

   // An empty cell or one with a strictly larger key lies after the new entry.
   assign gt = !occupied || (key_ff > ctrl.key);

   // Insert: shift right behind the insertion point, take the new entry at it.
   // Remove: every cell takes its right neighbor's entry.
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctrl.ins) begin
         if (gt && left_gt) begin
            key_in     = left_key;
            payload_in = left_payload;
         end else if (gt) begin
            key_in     = ctrl.key;
            payload_in = ctrl.payload;
         end
      end else if (ctrl.rem) begin
         key_in     = right_key;
         payload_in = right_payload;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule

`default_nettype wire

@@ hdl/sorted_insert_priority_queue_unit.sv @@
// Top level of the sorted insert priority queue: cell chain, count and response.
`default_nettype none

// A bounded min-priority queue of up to 256 key and payload entries held in a row
// of cells, smallest key at the head, equal keys in arrival order. A request is
// taken on every cycle that start is high; busy never rises. Each request gives
// exactly one response, shown with rsp_strobe for one cycle on the cycle after
// the request was accepted, so one request per cycle is sustained. That figure is
// set by the cell chain: all cells compare their keys with the new key at once and
// shift by one place together. Responses cannot be held off and must be captured
// when rsp_strobe is high. An insert into a full queue returns a full status and a
// remove from an empty queue an empty status, both leaving the queue as it was.
module sorted_insert_priority_queue_unit
   import spq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_kind,
   input  wire logic [KEY_BITS-1:0]     req_new_key,
   input  wire logic [PAYLOAD_BITS-1:0] req_new_payload,
   output logic                         rsp_strobe,
   output logic [STATUS_BITS-1:0]       rsp_status,
   output logic [COUNT_BITS-1:0]        rsp_entry_count,
   output logic                         rsp_head_valid,
   output logic [KEY_BITS-1:0]          rsp_head_key,
   output logic [PAYLOAD_BITS-1:0]      rsp_head_payload,
   output logic [KEY_BITS-1:0]          rsp_removed_key,
   output logic [PAYLOAD_BITS-1:0]      rsp_removed_payload
);

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

   logic                    accept;
   logic                    is_full;
   logic                    is_empty;
   cell_ctrl_type           ctrl;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;
   status_type              status;

   logic                    cell_gt      [QUEUE_DEPTH];
   logic                    cell_occ     [QUEUE_DEPTH];
   logic [KEY_BITS-1:0]     cell_key     [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_payload [QUEUE_DEPTH];

   logic [KEY_BITS-1:0]     head_key;
   logic [PAYLOAD_BITS-1:0] head_payload;
   logic [KEY_BITS-1:0]     removed_key;
   logic [PAYLOAD_BITS-1:0] removed_payload;

   logic                    rsp_strobe_ff;
   logic [STATUS_BITS-1:0]  rsp_status_ff;
   logic [COUNT_BITS-1:0]   rsp_count_ff;
   logic                    rsp_head_valid_ff;
   logic [KEY_BITS-1:0]     rsp_head_key_ff;
   logic [PAYLOAD_BITS-1:0] rsp_head_payload_ff;
   logic [KEY_BITS-1:0]     rsp_removed_key_ff;
   logic [PAYLOAD_BITS-1:0] rsp_removed_payload_ff;

   // No request is ever stalled, so the unit is always ready.
   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);

   // Decode the request into the operation broadcast to the cells.
   always_comb begin
      ctrl.ins     = accept && (req_kind == KIND_INSERT) && !is_full;
      ctrl.rem     = accept && (req_kind == KIND_REMOVE) && !is_empty;
      ctrl.key     = req_new_key;
      ctrl.payload = req_new_payload;
   end

   // The cell chain; a cell is occupied when its place is below the count.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                    left_gt;
      logic [KEY_BITS-1:0]     left_key;
      logic [PAYLOAD_BITS-1:0] left_payload;
      logic [KEY_BITS-1:0]     right_key;
      logic [PAYLOAD_BITS-1:0] right_payload;

      assign cell_occ[i] = (COUNT_BITS'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_gt      = 1'b0;
         assign left_key     = '0;
         assign left_payload = '0;
      end else begin : g_mid_left
         assign left_gt      = cell_gt[i-1];
         assign left_key     = cell_key[i-1];
         assign left_payload = cell_payload[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_key     = '0;
         assign right_payload = '0;
      end else begin : g_mid_right
         assign right_key     = cell_key[i+1];
         assign right_payload = cell_payload[i+1];
      end

      spq_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .occupied      (cell_occ[i]),
         .left_gt       (left_gt),
         .left_key      (left_key),
         .left_payload  (left_payload),
         .right_key     (right_key),
         .right_payload (right_payload),
         .gt            (cell_gt[i]),
         .key           (cell_key[i]),
         .payload       (cell_payload[i])
      );
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Status, head after the operation and the removed entry.
   always_comb begin
      status          = STATUS_OK;
      head_key        = cell_key[0];
      head_payload    = cell_payload[0];
      removed_key     = '0;
      removed_payload = '0;
      if (req_kind == KIND_INSERT) begin
         if (is_full) begin
            status = STATUS_FULL;
         end else if (cell_gt[0]) begin
            head_key     = req_new_key;
            head_payload = req_new_payload;
         end
      end else begin
         if (is_empty) begin
            status = STATUS_EMPTY;
         end else begin
            removed_key     = cell_key[0];
            removed_payload = cell_payload[0];
            head_key        = cell_key[1];
            head_payload    = cell_payload[1];
         end
      end
      if (count_in == '0) begin
         head_key     = '0;
         head_payload = '0;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff          <= status;
         rsp_count_ff           <= count_in;
         rsp_head_valid_ff      <= (count_in != '0);
         rsp_head_key_ff        <= head_key;
         rsp_head_payload_ff    <= head_payload;
         rsp_removed_key_ff     <= removed_key;
         rsp_removed_payload_ff <= removed_payload;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_count     = rsp_count_ff;
   assign rsp_head_valid      = rsp_head_valid_ff;
   assign rsp_head_key        = rsp_head_key_ff;
   assign rsp_head_payload    = rsp_head_payload_ff;
   assign rsp_removed_key     = rsp_removed_key_ff;
   assign rsp_removed_payload = rsp_removed_payload_ff;

   // The count never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above queue depth");

   // Every accepted request gets its response on the next cycle.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept) |=> rsp_strobe)
      else $error("accepted request produced no response");

   // A full status is only reported with a full queue.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_FULL) |-> rsp_entry_count == FULL_COUNT)
      else $error("full status with queue not full");

   // The first two occupied cells stay in ascending key order.
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_occ[1] |-> cell_key[0] <= cell_key[1])
      else $error("head entry out of order");

endmodule

`default_nettype wire

@@ dv/spq_checker.sv @@
// Response checker for the sorted insert priority queue: predicts and compares.
`timescale 1ns / 1ps

module spq_checker
   import spq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    busy,
   input  wire logic                    req_kind,
   input  wire logic [KEY_BITS-1:0]     req_new_key,
   input  wire logic [PAYLOAD_BITS-1:0] req_new_payload,
   input  wire logic                    rsp_strobe,
   input  wire logic [STATUS_BITS-1:0]  rsp_status,
   input  wire logic [COUNT_BITS-1:0]   rsp_entry_count,
   input  wire logic                    rsp_head_valid,
   input  wire logic [KEY_BITS-1:0]     rsp_head_key,
   input  wire logic [PAYLOAD_BITS-1:0] rsp_head_payload,
   input  wire logic [KEY_BITS-1:0]     rsp_removed_key,
   input  wire logic [PAYLOAD_BITS-1:0] rsp_removed_payload,
   output int                           mismatch_count,
   output int                           pending_count,
   output int                           checked_count,
   output int                           full_count,
   output int                           empty_count,
   output int                           peak_depth
);

   // One response as the queue should report it.
   typedef struct packed {
      status_type              status;
      logic [COUNT_BITS-1:0]   entry_count;
      logic                    head_valid;
      logic [KEY_BITS-1:0]     head_key;
      logic [PAYLOAD_BITS-1:0] head_payload;
      logic [KEY_BITS-1:0]     removed_key;
      logic [PAYLOAD_BITS-1:0] removed_payload;
   } queue_outcome_type;

   // Shadow copy of the queue contents, kept sorted by ascending key.
   logic [KEY_BITS-1:0]     shadow_keys     [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0] shadow_payloads [QUEUE_DEPTH];
   int                      shadow_held = 0;

   // Outcomes of accepted requests whose responses have not come yet.
   queue_outcome_type awaited_outcomes [$];

   int errors   = 0;
   int checked  = 0;
   int fulls    = 0;
   int empties  = 0;
   int deepest  = 0;

   // Applies one request to the shadow queue and returns the response it should give.
   function automatic queue_outcome_type apply_queue_op(input kind_type kind,
                                                        input logic [KEY_BITS-1:0] key,
                                                        input logic [PAYLOAD_BITS-1:0] payload);
      queue_outcome_type outcome;
      int slot;
      int i;
      outcome = '0;
      outcome.status = STATUS_OK;
      if (kind == KIND_INSERT) begin
         if (shadow_held >= QUEUE_DEPTH) begin
            outcome.status = STATUS_FULL;
         end else begin
            // The new entry goes after every stored entry with a key not above it.
            slot = 0;
            while (slot < shadow_held && shadow_keys[slot] <= key) slot++;
            for (i = shadow_held; i > slot; i--) begin
               shadow_keys[i]     = shadow_keys[i-1];
               shadow_payloads[i] = shadow_payloads[i-1];
            end
            shadow_keys[slot]     = key;
            shadow_payloads[slot] = payload;
            shadow_held++;
         end
      end else begin
         if (shadow_held == 0) begin
            outcome.status = STATUS_EMPTY;
         end else begin
            outcome.removed_key     = shadow_keys[0];
            outcome.removed_payload = shadow_payloads[0];
            for (i = 1; i < shadow_held; i++) begin
               shadow_keys[i-1]     = shadow_keys[i];
               shadow_payloads[i-1] = shadow_payloads[i];
            end
            shadow_held--;
         end
      end
      outcome.entry_count = COUNT_BITS'(shadow_held);
      outcome.head_valid  = (shadow_held > 0);
      if (shadow_held > 0) begin
         outcome.head_key     = shadow_keys[0];
         outcome.head_payload = shadow_payloads[0];
      end
      return outcome;
   endfunction

   function automatic string describe(input queue_outcome_type o);
      return $sformatf("status %0d count %0d head %0b %06h/%03h removed %06h/%03h",
                       o.status, o.entry_count, o.head_valid, o.head_key,
                       o.head_payload, o.removed_key, o.removed_payload);
   endfunction

   // Compare each response with the oldest outstanding request, then log new requests.
   always @(posedge clock) begin : watch
      queue_outcome_type observed;
      queue_outcome_type predicted;
      if (reset) begin
         shadow_held = 0;
         awaited_outcomes.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            observed.status          = status_type'(rsp_status);
            observed.entry_count     = rsp_entry_count;
            observed.head_valid      = rsp_head_valid;
            observed.head_key        = rsp_head_key;
            observed.head_payload    = rsp_head_payload;
            observed.removed_key     = rsp_removed_key;
            observed.removed_payload = rsp_removed_payload;
            if (awaited_outcomes.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("checker: response with no request outstanding: %s",
                           describe(observed));
            end else begin
               predicted = awaited_outcomes.pop_front();
               checked++;
               if (observed !== predicted) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("checker: mismatch at %0t", $realtime);
                     $display("   expected %s", describe(predicted));
                     $display("   actual   %s", describe(observed));
                  end
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            predicted = apply_queue_op(kind_type'(req_kind), req_new_key, req_new_payload);
            awaited_outcomes.push_back(predicted);
            if (predicted.status == STATUS_FULL) fulls++;
            if (predicted.status == STATUS_EMPTY) empties++;
            if (shadow_held > deepest) deepest = shadow_held;
         end
      end
      mismatch_count <= errors;
      pending_count  <= awaited_outcomes.size();
      checked_count  <= checked;
      full_count     <= fulls;
      empty_count    <= empties;
      peak_depth     <= deepest;
   end

endmodule

@@ dv/testbench.sv @@
// Top of the sorted insert priority queue testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module testbench;
   import spq_pkg::*;

   localparam logic [KEY_BITS-1:0]     KEY_MAX     = {KEY_BITS{1'b1}};
   localparam logic [PAYLOAD_BITS-1:0] PAYLOAD_MAX = {PAYLOAD_BITS{1'b1}};

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_kind;
   logic [KEY_BITS-1:0]     req_new_key;
   logic [PAYLOAD_BITS-1:0] req_new_payload;
   logic                    rsp_strobe;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic [COUNT_BITS-1:0]   rsp_entry_count;
   logic                    rsp_head_valid;
   logic [KEY_BITS-1:0]     rsp_head_key;
   logic [PAYLOAD_BITS-1:0] rsp_head_payload;
   logic [KEY_BITS-1:0]     rsp_removed_key;
   logic [PAYLOAD_BITS-1:0] rsp_removed_payload;

   int mismatches;
   int outstanding;
   int responses_checked;
   int full_rejects;
   int empty_removes;
   int peak_depth;
   int inserts_sent = 0;
   int removes_sent = 0;

   sorted_insert_priority_queue_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_new_key         (req_new_key),
      .req_new_payload     (req_new_payload),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_key        (rsp_head_key),
      .rsp_head_payload    (rsp_head_payload),
      .rsp_removed_key     (rsp_removed_key),
      .rsp_removed_payload (rsp_removed_payload)
   );

   spq_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_new_key         (req_new_key),
      .req_new_payload     (req_new_payload),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_key        (rsp_head_key),
      .rsp_head_payload    (rsp_head_payload),
      .rsp_removed_key     (rsp_removed_key),
      .rsp_removed_payload (rsp_removed_payload),
      .mismatch_count      (mismatches),
      .pending_count       (outstanding),
      .checked_count       (responses_checked),
      .full_count          (full_rejects),
      .empty_count         (empty_removes),
      .peak_depth          (peak_depth)
   );

   // Free-running clock with a 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   // Presents one request and returns once it has been accepted.
   task automatic send_op(input kind_type kind, input logic [KEY_BITS-1:0] key,
                          input logic [PAYLOAD_BITS-1:0] payload);
      start           <= 1'b1;
      req_kind        <= kind;
      req_new_key     <= key;
      req_new_payload <= payload;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind == KIND_INSERT) inserts_sent++;
      else removes_sent++;
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stops sending until every outstanding request has its response, or a limit runs out.
   task automatic wait_for_drain(input int limit);
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Keys lean toward the extremes and a narrow band so that equal keys are common.
   function automatic logic [KEY_BITS-1:0] pick_key();
      int mode;
      mode = $urandom_range(0, 9);
      case (mode)
         0:       return '0;
         1:       return KEY_MAX;
         2, 3, 4: return KEY_BITS'($urandom_range(0, 7));
         default: return KEY_BITS'({$urandom(), $urandom()});
      endcase
   endfunction

   // Mostly back to back, often a short gap, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic run_phase(input int items, input int insert_pct, input bit with_gaps);
      kind_type kind;
      int n;
      for (n = 0; n < items; n++) begin
         if ($urandom_range(0, 99) < insert_pct) kind = KIND_INSERT;
         else kind = KIND_REMOVE;
         send_op(kind, pick_key(), PAYLOAD_BITS'($urandom()));
         if (with_gaps) hold_off(pick_gap());
      end
   endtask

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_kind        <= KIND_INSERT;
      req_new_key     <= '0;
      req_new_payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: remove when empty, extreme keys and payloads, equal keys in order.
      send_op(KIND_REMOVE, KEY_MAX, PAYLOAD_MAX);
      send_op(KIND_INSERT, KEY_MAX, PAYLOAD_MAX);
      send_op(KIND_INSERT, '0, '0);
      send_op(KIND_INSERT, KEY_BITS'(5), PAYLOAD_BITS'(1));
      send_op(KIND_INSERT, KEY_BITS'(5), PAYLOAD_BITS'(2));
      send_op(KIND_INSERT, KEY_BITS'(5), PAYLOAD_BITS'(3));
      send_op(KIND_INSERT, '0, PAYLOAD_BITS'(9'h155));
      send_op(KIND_INSERT, KEY_MAX, PAYLOAD_BITS'(9'h0AA));
      send_op(KIND_INSERT, KEY_BITS'(24'h800000), PAYLOAD_BITS'(9'h100));
      repeat (8) send_op(KIND_REMOVE, '0, '0);
      send_op(KIND_REMOVE, '0, PAYLOAD_MAX);
      wait_for_drain(100);

      // Random: mixed, fill past full, drain past empty, then mixed again.
      run_phase(200, 50, 1'b1);
      wait_for_drain(100);
      run_phase(330, 95, 1'b0);
      wait_for_drain(100);
      run_phase(330, 5, 1'b1);
      wait_for_drain(100);
      run_phase(370, 55, 1'b1);

      wait_for_drain(1000);
      repeat (8) @(posedge clock);

      $display("tb: sent %0d inserts and %0d removes, %0d responses checked",
               inserts_sent, removes_sent, responses_checked);
      $display("tb: peak depth %0d, %0d inserts refused as full, %0d removes on empty",
               peak_depth, full_rejects, empty_removes);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sorted_insert_priority_queue_unit.f @@
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_insert_priority_queue_unit.sv
dv/spq_checker.sv
dv/testbench.sv
